[hdl/jsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape package
// Result status codes and the packet that carries the result beats of one
// source byte from the front end, through the queue, to the back end.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int SlotCount = 4;

   localparam logic [1:0] ST_BYTE   = 2'd0;
   localparam logic [1:0] ST_CLOSED = 2'd1;
   localparam logic [1:0] ST_BAD    = 2'd2;

   typedef struct packed {
      logic [2:0]                 count;
      logic [SlotCount-1:0][7:0]  data;
      logic [SlotCount-1:0][1:0]  status;
   } packet_type;

   typedef struct packed {
      logic       push;
      packet_type packet;
   } push_type;

   typedef struct packed {
      logic       valid;
      packet_type packet;
   } head_type;

endpackage

[hdl/jsu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Accepts one source byte per beat, runs the literal parser and turns the
// byte into a packet of up to four result beats for the queue.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_in_last,
   input  logic               queue_full,
   output jsu_pkg::push_type  push
);

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_BODY     = 3'd1;
   localparam logic [2:0] PH_ESC      = 3'd2;
   localparam logic [2:0] PH_HEX      = 3'd3;
   localparam logic [2:0] PH_HOLD     = 3'd4;
   localparam logic [2:0] PH_HOLD_ESC = 3'd5;
   localparam logic [2:0] PH_LOW      = 3'd6;

   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] data;
   } enc_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] value;
   } lookup_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   function automatic enc_type utf8_encode(input logic [20:0] cp);
      enc_type e;
      e = '0;
      if (cp < 21'h80) begin
         e.len     = 3'd1;
         e.data[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         e.len     = 3'd2;
         e.data[0] = {3'b110, cp[10:6]};
         e.data[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         e.len     = 3'd3;
         e.data[0] = {4'b1110, cp[15:12]};
         e.data[1] = {2'b10, cp[11:6]};
         e.data[2] = {2'b10, cp[5:0]};
      end else begin
         e.len     = 3'd4;
         e.data[0] = {5'b11110, cp[20:18]};
         e.data[1] = {2'b10, cp[17:12]};
         e.data[2] = {2'b10, cp[11:6]};
         e.data[3] = {2'b10, cp[5:0]};
      end
      return e;
   endfunction

   function automatic lookup_type escape_map(input logic [7:0] b);
      lookup_type r;
      r.ok = 1'b1;
      case (b)
         8'h22:   r.value = 8'h22;
         8'h5C:   r.value = 8'h5C;
         8'h2F:   r.value = 8'h2F;
         8'h62:   r.value = 8'h08;
         8'h66:   r.value = 8'h0C;
         8'h6E:   r.value = 8'h0A;
         8'h72:   r.value = 8'h0D;
         8'h74:   r.value = 8'h09;
         default: begin
            r.ok    = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

   function automatic digit_type hex_digit(input logic [7:0] b);
      digit_type r;
      r.ok = 1'b1;
      case (b) inside
         [8'h30:8'h39]: r.value = b[3:0];
         [8'h41:8'h46],
         [8'h61:8'h66]: r.value = b[3:0] + 4'd9;
         default: begin
            r.ok    = 1'b0;
            r.value = 4'd0;
         end
      endcase
      return r;
   endfunction

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] hex_ff, hex_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic [9:0]  high_ff, high_in;

   logic        accept;
   logic        bad, closed, emit_cp, emit_single, is_last;
   logic [20:0] cp;
   logic [7:0]  single;
   logic [15:0] hex_new;
   lookup_type  esc;
   digit_type   dig;
   enc_type     enc;
   logic [2:0]  nbytes, total;
   jsu_pkg::packet_type pkt;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign esc       = escape_map(req_in_byte);
   assign dig       = hex_digit(req_in_byte);
   assign hex_new   = {hex_ff[11:0], dig.value};

   always_comb begin
      phase_in    = phase_ff;
      hex_in      = hex_ff;
      dcnt_in     = dcnt_ff;
      high_in     = high_ff;
      bad         = 1'b0;
      closed      = 1'b0;
      emit_cp     = 1'b0;
      emit_single = 1'b0;
      cp          = {5'd0, 6'b110110, high_ff};
      single      = req_in_byte;
      case (phase_ff)
         PH_BODY: begin
            if (req_in_byte == 8'h22) begin
               closed = 1'b1;
            end else if (req_in_byte == 8'h5C) begin
               phase_in = PH_ESC;
            end else begin
               emit_single = 1'b1;
            end
         end
         PH_ESC: begin
            if (esc.ok) begin
               emit_single = 1'b1;
               single      = esc.value;
               phase_in    = PH_BODY;
            end else if (req_in_byte == 8'h75) begin
               hex_in   = '0;
               dcnt_in  = '0;
               phase_in = PH_HEX;
            end else begin
               bad = 1'b1;
            end
         end
         PH_HEX, PH_LOW: begin
            if (!dig.ok) begin
               bad = 1'b1;
            end else begin
               hex_in = hex_new;
               if (dcnt_ff != 2'd3) begin
                  dcnt_in = dcnt_ff + 2'd1;
               end else begin
                  dcnt_in = '0;
                  if (phase_ff == PH_HEX) begin
                     if (hex_new inside {[16'hD800:16'hDBFF]}) begin
                        high_in  = hex_new[9:0];
                        phase_in = PH_HOLD;
                     end else begin
                        emit_cp  = 1'b1;
                        cp       = {5'd0, hex_new};
                        phase_in = PH_BODY;
                     end
                  end else if (hex_new inside {[16'hDC00:16'hDFFF]}) begin
                     emit_cp  = 1'b1;
                     cp       = 21'h10000 + {1'b0, high_ff, hex_new[9:0]};
                     phase_in = PH_BODY;
                  end else begin
                     bad = 1'b1;
                  end
               end
            end
         end
         PH_HOLD: begin
            if (req_in_byte == 8'h5C) begin
               phase_in = PH_HOLD_ESC;
            end else begin
               emit_cp  = 1'b1;
               phase_in = PH_BODY;
               if (req_in_byte == 8'h22) begin
                  closed = 1'b1;
               end else begin
                  emit_single = 1'b1;
               end
            end
         end
         PH_HOLD_ESC: begin
            if (req_in_byte == 8'h75) begin
               hex_in   = '0;
               dcnt_in  = '0;
               phase_in = PH_LOW;
            end else begin
               emit_cp = 1'b1;
               if (esc.ok) begin
                  emit_single = 1'b1;
                  single      = esc.value;
                  phase_in    = PH_BODY;
               end else begin
                  bad = 1'b1;
               end
            end
         end
         default: begin
            if (req_in_byte == 8'h22) begin
               phase_in = PH_BODY;
            end else begin
               bad = 1'b1;
            end
         end
      endcase
      if (!bad && !closed && req_in_last) begin
         bad = 1'b1;
      end
      if (bad || closed) begin
         phase_in = PH_IDLE;
         hex_in   = '0;
         dcnt_in  = '0;
         high_in  = '0;
      end
   end

   assign enc     = utf8_encode(cp);
   assign nbytes  = (emit_cp ? enc.len : 3'd0) + {2'd0, emit_single};
   assign is_last = bad || closed;
   assign total   = bad ? 3'd1 : nbytes + {2'd0, closed};

   always_comb begin
      pkt       = '0;
      pkt.count = total;
      for (int k = 0; k < jsu_pkg::SlotCount; k++) begin
         if (bad) begin
            if (k == 0) begin
               pkt.status[k] = jsu_pkg::ST_BAD;
            end
         end else if (emit_cp && (3'(k) < enc.len)) begin
            pkt.data[k] = enc.data[k];
         end else if (3'(k) < nbytes) begin
            pkt.data[k] = single;
         end else if (closed && (3'(k) == nbytes)) begin
            pkt.status[k] = jsu_pkg::ST_CLOSED;
         end
      end
   end

   assign push.push   = accept && ((total != 3'd0) || is_last);
   assign push.packet = pkt;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hex_ff   <= '0;
         dcnt_ff  <= '0;
         high_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
         dcnt_ff  <= dcnt_in;
         high_ff  <= high_in;
      end
   end

endmodule

[hdl/jsu_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape packet queue
// Two-entry queue of result packets between the front end and the back end.
// ----------------------------------------------------------------------------
module jsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  jsu_pkg::push_type  push,
   input  logic               pop,
   output logic               full,
   output jsu_pkg::head_type  head
);

   jsu_pkg::packet_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full        = (fill_ff == 2'd2);
   assign do_push     = push.push && !full;
   assign do_pop      = pop && (fill_ff != 2'd0);
   assign head.valid  = (fill_ff != 2'd0);
   assign head.packet = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff ^ do_push;
   assign rd_ptr_in = rd_ptr_ff ^ do_pop;
   assign fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.packet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[hdl/jsu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape back end
// Walks the packet at the head of the queue and presents its result beats
// one at a time, marking the final beat of each packet.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  jsu_pkg::head_type  head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       beat;

   assign rsp_valid    = head.valid;
   assign rsp_out_byte = head.packet.data[idx_ff];
   assign rsp_status   = head.packet.status[idx_ff];
   assign rsp_last     = ({1'b0, idx_ff} == (head.packet.count - 3'd1));
   assign beat         = rsp_valid && rsp_ready;
   assign pop          = beat && rsp_last;

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (beat) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[hdl/json_string_unescape_utf8.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes one JSON string literal at a time, one source byte per beat, into
// UTF-8 bytes followed by a closed or malformed status beat.
// ----------------------------------------------------------------------------
// A source byte is taken in the cycle it is offered whenever the two-entry
// packet queue has room; its result beats are registered in the queue before
// they reach the result port. A source byte yields zero to four result beats,
// and the back end sends one beat per cycle while the result port is ready,
// so the input sustains one byte per cycle while each byte yields at most one
// beat; a byte that ends a surrogate pair or a multi-byte code point holds
// the input back once the queue has filled. Bytes that yield no beat never
// occupy the queue. A malformed literal gives a single status beat; the
// consumer must drop the bytes already sent for it, as the block does not.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   jsu_pkg::push_type push;
   jsu_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .queue_full  (queue_full),
      .push        (push)
   );

   jsu_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

[hdl/jsu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape port checker
// Checks both ports against the handshake rules and the rules of the decoded
// beat stream.
// ----------------------------------------------------------------------------
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_byte)
         && $stable(req_in_last))
      else $error("Waiting source beat changed.");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("Stalled result beat changed.");

   a_status_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != jsu_pkg::ST_BYTE) |-> rsp_last)
      else $error("Status beat is not the final beat of its byte.");

   a_status_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != jsu_pkg::ST_BYTE) |-> (rsp_out_byte == 8'h00))
      else $error("Status beat carries a non-zero byte.");

   a_after_reset : assert property (@(posedge clock)
      $fell(reset) |-> req_ready && !rsp_valid)
      else $error("Block not empty and ready after reset.");

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (.*);

[tb/json_string_unescape_utf8_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8 testbench
// Feeds directed and randomised source bytes, mostly whole literals with
// random content and some broken ones, under several idling profiles on both
// channels. Every result beat is checked against a decoder modelled here.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = "u";
   localparam logic [63:0] ESCAPE_LETTERS = {"\"", "\\", "/", "b", "f", "n", "r", "t"};

   localparam int LIT_CLOSED     = 0;
   localparam int LIT_SHORT      = 1;
   localparam int LIT_BAD_ESCAPE = 2;
   localparam int LIT_BAD_HEX    = 3;
   localparam int LIT_BAD_LOW    = 4;
   localparam int LIT_NOISE      = 5;
   localparam int LIT_KINDS      = 6;

   typedef enum logic [2:0] {
      PH_IDLE, PH_BODY, PH_ESC, PH_HEX, PH_HOLD, PH_HOLD_ESC, PH_LOW
   } scan_phase_type;

   typedef struct {
      logic [7:0] data;
      logic [1:0] status;
      logic       last;
   } beat_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } source_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_last;

   source_type source_bytes[$];
   beat_type   decoded_beats[$];
   beat_type   burst[$];
   source_type next_source;
   beat_type   wanted;

   scan_phase_type scan_phase = PH_IDLE;
   logic [15:0] hex_acc    = 16'h0000;
   logic [1:0]  hex_digits = 2'd0;
   logic [15:0] held_high  = 16'h0000;

   int fault_count    = 0;
   int source_count   = 0;
   int literal_serial = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   json_string_unescape_utf8 dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------
   function automatic void push_beat(logic [7:0] data, logic [1:0] status);
      beat_type b;
      if (burst.size() < 4) begin
         b.data   = (status == jsu_pkg::ST_BYTE) ? data : 8'h00;
         b.status = status;
         b.last   = 1'b0;
         burst.push_back(b);
      end
   endfunction

   function automatic void encode_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
         push_beat(cp[7:0], jsu_pkg::ST_BYTE);
      end else if (cp < 21'h800) begin
         push_beat(8'hC0 | {3'b000, cp[10:6]}, jsu_pkg::ST_BYTE);
         push_beat(8'h80 | {2'b00, cp[5:0]}, jsu_pkg::ST_BYTE);
      end else if (cp < 21'h10000) begin
         push_beat(8'hE0 | {4'h0, cp[15:12]}, jsu_pkg::ST_BYTE);
         push_beat(8'h80 | {2'b00, cp[11:6]}, jsu_pkg::ST_BYTE);
         push_beat(8'h80 | {2'b00, cp[5:0]}, jsu_pkg::ST_BYTE);
      end else begin
         push_beat(8'hF0 | {5'b00000, cp[20:18]}, jsu_pkg::ST_BYTE);
         push_beat(8'h80 | {2'b00, cp[17:12]}, jsu_pkg::ST_BYTE);
         push_beat(8'h80 | {2'b00, cp[11:6]}, jsu_pkg::ST_BYTE);
         push_beat(8'h80 | {2'b00, cp[5:0]}, jsu_pkg::ST_BYTE);
      end
   endfunction

   function automatic int hex_value_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   function automatic bit take_body(logic [7:0] b);
      if (b == CH_QUOTE) return 1'b1;
      if (b == CH_BSLASH) scan_phase = PH_ESC;
      else push_beat(b, jsu_pkg::ST_BYTE);
      return 1'b0;
   endfunction

   function automatic bit take_escape(logic [7:0] b);
      logic [7:0] v;
      bit ok;
      ok = 1'b1;
      v  = 8'h00;
      case (b)
         CH_QUOTE:  v = CH_QUOTE;
         CH_BSLASH: v = CH_BSLASH;
         "/":       v = "/";
         "b":       v = 8'h08;
         "f":       v = 8'h0C;
         "n":       v = 8'h0A;
         "r":       v = 8'h0D;
         "t":       v = 8'h09;
         CH_U: begin
            hex_acc    = 16'h0000;
            hex_digits = 2'd0;
            scan_phase = PH_HEX;
         end
         default:   ok = 1'b0;
      endcase
      if (ok && b != CH_U) begin
         push_beat(v, jsu_pkg::ST_BYTE);
         scan_phase = PH_BODY;
      end
      return ok;
   endfunction

   function automatic void clear_scan();
      scan_phase = PH_IDLE;
      hex_acc    = 16'h0000;
      hex_digits = 2'd0;
      held_high  = 16'h0000;
   endfunction

   function automatic void decode_source_byte(logic [7:0] b, logic src_end);
      bit bad;
      bit closed;
      int d;
      int unsigned pair_cp;
      beat_type bt;
      bad    = 1'b0;
      closed = 1'b0;
      burst.delete();
      case (scan_phase)
         PH_BODY: closed = take_body(b);
         PH_ESC:  bad = !take_escape(b);
         PH_HEX, PH_LOW: begin
            d = hex_value_of(b);
            if (d < 0) begin
               bad = 1'b1;
            end else begin
               hex_acc = {hex_acc[11:0], d[3:0]};
               if (hex_digits < 2'd3) begin
                  hex_digits++;
               end else begin
                  hex_digits = 2'd0;
                  if (scan_phase == PH_HEX) begin
                     if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                        held_high  = hex_acc;
                        scan_phase = PH_HOLD;
                     end else begin
                        encode_code_point({5'd0, hex_acc});
                        scan_phase = PH_BODY;
                     end
                  end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                     pair_cp = 32'h10000 + ((held_high - 32'hD800) << 10)
                               + (hex_acc - 32'hDC00);
                     encode_code_point(pair_cp[20:0]);
                     scan_phase = PH_BODY;
                  end else begin
                     bad = 1'b1;
                  end
               end
            end
         end
         PH_HOLD: begin
            if (b == CH_BSLASH) begin
               scan_phase = PH_HOLD_ESC;
            end else begin
               encode_code_point({5'd0, held_high});
               scan_phase = PH_BODY;
               closed = take_body(b);
            end
         end
         PH_HOLD_ESC: begin
            if (b == CH_U) begin
               hex_acc    = 16'h0000;
               hex_digits = 2'd0;
               scan_phase = PH_LOW;
            end else begin
               encode_code_point({5'd0, held_high});
               bad = !take_escape(b);
            end
         end
         default: begin
            if (b == CH_QUOTE) scan_phase = PH_BODY;
            else bad = 1'b1;
         end
      endcase
      if (!bad && !closed && src_end) bad = 1'b1;
      if (bad) begin
         burst.delete();
         push_beat(8'h00, jsu_pkg::ST_BAD);
         clear_scan();
      end else if (closed) begin
         push_beat(8'h00, jsu_pkg::ST_CLOSED);
         clear_scan();
      end
      foreach (burst[i]) begin
         bt      = burst[i];
         bt.last = (i == burst.size() - 1);
         decoded_beats.push_back(bt);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Source text generation
   // ------------------------------------------------------------------------
   function automatic void add_byte(logic [7:0] data, logic last);
      source_type s;
      s.data = data;
      s.last = last;
      source_bytes.push_back(s);
      source_count++;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return {4'h0, nib} + "0";
      if ($urandom_range(0, 1) == 1) return {4'h0, nib} - 8'd10 + "A";
      return {4'h0, nib} - 8'd10 + "a";
   endfunction

   function automatic void add_hex(logic [15:0] v, int ndigits, logic last_end);
      add_byte(CH_BSLASH, 1'b0);
      add_byte(CH_U, last_end && ndigits == 0);
      for (int i = 0; i < ndigits; i++)
         add_byte(hex_char(v[15 - 4 * i -: 4]), last_end && i == ndigits - 1);
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
      return b;
   endfunction

   function automatic logic [7:0] bad_letter();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      case (b)
         CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", CH_U: b = "x";
         default: ;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] non_hex();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (hex_value_of(b) >= 0) b = "g";
      return b;
   endfunction

   function automatic logic [15:0] high_half();
      return 16'($urandom_range(16'hD800, 16'hDBFF));
   endfunction

   function automatic logic [15:0] low_half();
      return 16'($urandom_range(16'hDC00, 16'hDFFF));
   endfunction

   function automatic void add_simple_escape();
      int i;
      i = int'($urandom_range(0, 7));
      add_byte(CH_BSLASH, 1'b0);
      add_byte(ESCAPE_LETTERS[8 * i +: 8], 1'b0);
   endfunction

   function automatic void add_piece();
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: add_byte(plain_byte(), 1'b0);
         3:       add_simple_escape();
         4:       add_hex(16'($urandom_range(0, 16'h7F)), 4, 1'b0);
         5:       add_hex(16'($urandom_range(16'h80, 16'h7FF)), 4, 1'b0);
         6: begin
            v = 16'($urandom_range(16'h800, 16'hFFFF));
            if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
            add_hex(v, 4, 1'b0);
         end
         7: begin
            add_hex(high_half(), 4, 1'b0);
            add_hex(low_half(), 4, 1'b0);
         end
         8:       add_hex(low_half(), 4, 1'b0);
         default: begin
            add_hex(high_half(), 4, 1'b0);
            if ($urandom_range(0, 1) == 1) add_byte(plain_byte(), 1'b0);
            else add_simple_escape();
         end
      endcase
   endfunction

   function automatic void add_literal(int kind);
      logic [15:0] v;
      if (kind == LIT_NOISE) begin
         repeat ($urandom_range(1, 3))
            add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         return;
      end
      add_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(1, 5)) add_piece();
      case (kind)
         LIT_CLOSED: begin
            if ($urandom_range(0, 3) == 0) add_hex(high_half(), 4, 1'b0);
            add_byte(CH_QUOTE, 1'($urandom_range(0, 1)));
         end
         LIT_SHORT: begin
            case ($urandom_range(0, 3))
               0:       add_byte(plain_byte(), 1'b1);
               1:       add_byte(CH_BSLASH, 1'b1);
               2:       add_hex(16'($urandom_range(0, 16'hFFFF)),
                                int'($urandom_range(0, 3)), 1'b1);
               default: add_hex(high_half(), 4, 1'b1);
            endcase
         end
         LIT_BAD_ESCAPE: begin
            if ($urandom_range(0, 1) == 1) add_hex(high_half(), 4, 1'b0);
            add_byte(CH_BSLASH, 1'b0);
            add_byte(bad_letter(), 1'($urandom_range(0, 1)));
         end
         LIT_BAD_HEX: begin
            if ($urandom_range(0, 1) == 1) add_hex(high_half(), 4, 1'b0);
            add_hex(16'($urandom_range(0, 16'hFFFF)), int'($urandom_range(0, 3)), 1'b0);
            add_byte(non_hex(), 1'($urandom_range(0, 1)));
         end
         default: begin
            add_hex(high_half(), 4, 1'b0);
            v = 16'($urandom_range(0, 16'hFFFF));
            if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h2000;
            add_hex(v, 4, 1'($urandom_range(0, 1)));
         end
      endcase
   endfunction

   function automatic void add_random_text(int count);
      int target;
      int r;
      target = source_count + count;
      while (source_count < target) begin
         r = int'($urandom_range(0, 99));
         if (literal_serial < LIT_KINDS) add_literal(literal_serial);
         else if (r < 60) add_literal(LIT_CLOSED);
         else add_literal((r - 60) / 8 + 1);
         literal_serial++;
      end
   endfunction

   task automatic drain();
      while (source_bytes.size() != 0 || req_valid || decoded_beats.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Driver and monitor
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_source_byte(req_in_byte, req_in_last);
         end
         if (!req_valid || req_ready) begin
            if (source_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_source = source_bytes.pop_front();
               req_valid   <= 1'b1;
               req_in_byte <= next_source.data;
               req_in_last <= next_source.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_beats.size() == 0) begin
               $display({"%0t: unexpected beat, expected none, ",
                         "actual byte %02h status %0d last %0b"},
                        $time, rsp_out_byte, rsp_status, rsp_last);
               fault_count++;
            end else begin
               wanted = decoded_beats.pop_front();
               if (rsp_out_byte !== wanted.data) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, wanted.data, rsp_out_byte);
                  fault_count++;
               end
               if (rsp_status !== wanted.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, wanted.status, rsp_status);
                  fault_count++;
               end
               if (rsp_last !== wanted.last) begin
                  $display("%0t: last expected %0b actual %0b",
                           $time, wanted.last, rsp_last);
                  fault_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (3) @(negedge clock);

      // A stray byte while idle, then a literal with a raw FF byte, an escaped
      // solidus, the highest surrogate pair and a lone low surrogate.
      add_byte(8'h00, 1'b0);
      add_byte(CH_QUOTE, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(CH_BSLASH, 1'b0);
      add_byte("/", 1'b0);
      add_hex(16'hDBFF, 4, 1'b0);
      add_hex(16'hDFFF, 4, 1'b0);
      add_hex(16'hDC00, 4, 1'b0);
      add_byte(CH_QUOTE, 1'b1);
      add_random_text(30);
      drain();

      send_idle_pct = 83;
      add_random_text(30);
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 83;
      add_random_text(30);
      drain();

      send_idle_pct  = 35;
      recv_stall_pct = 35;
      add_random_text(30);
      drain();

      repeat (16) @(posedge clock);
      if (fault_count == 0 && decoded_beats.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
